/* rtl/halton_radical_inverse_macros.svh */
// Assertion macros shared by the radical inverse RTL.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef HALTON_RADICAL_INVERSE_MACROS_SVH
`define HALTON_RADICAL_INVERSE_MACROS_SVH

// condition must hold at every edge outside reset
`define HRI_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent at the same edge
`define HRI_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent at the next edge
`define HRI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/hri_pkg.sv */
// Types and constants for the radical inverse block.
// No dependencies; used by every module of the block.
`default_nettype none
package hri_pkg;

	localparam int BASE_W = 8;

	typedef logic [BASE_W-1:0] base_t;

	localparam base_t MIN_BASE   = base_t'(2);
	localparam base_t RESET_BASE = base_t'(2);

	// radix in use: values below two act as two
	function automatic base_t eff_base(input base_t raw);
		eff_base = (raw < MIN_BASE) ? MIN_BASE : raw;
	endfunction

endpackage
`default_nettype wire

/* rtl/hri_recip.sv */
// Base register and reciprocal unit: floor(2^IB / base), one quotient bit a cycle.
// Depends on hri_pkg and halton_radical_inverse_macros.svh.
`default_nettype none
`include "halton_radical_inverse_macros.svh"
module hri_recip import hri_pkg::*; #(
	parameter int IB = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire base_t         base,
	output base_t              b_eff,
	output logic [IB-1:0]      recip,
	output logic               busy
);
	localparam int CW = $clog2(IB + 1);

	base_t           base_q;
	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [BASE_W-1:0] rem_q;
	logic [IB-1:0]   m_q;
	logic [BASE_W:0] rem2;
	logic            ge;

	assign b_eff     = eff_base(base_q);
	assign recip     = m_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign rem2      = {rem_q, 1'b0};
	assign ge        = rem2 >= {1'b0, b_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= RESET_BASE;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			m_q    <= {1'b1, {(IB-1){1'b0}}};
		end else if (busy_q) begin
			rem_q <= ge ? BASE_W'(rem2 - {1'b0, b_eff}) : rem_q << 1;
			m_q   <= {m_q[IB-2:0], ge};
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end else if (cfg_valid) begin
			base_q <= base;
			busy_q <= 1'b1;
			cnt_q  <= CW'(IB);
			rem_q  <= BASE_W'(1);
			m_q    <= '0;
		end
	end

	logic [IB+8:0] mb;
	logic [IB+8:0] mb1;
	logic [IB+8:0] one_shl;
	assign mb      = (IB+9)'(m_q) * (IB+9)'(b_eff);
	assign mb1     = mb + (IB+9)'(b_eff);
	assign one_shl = (IB+9)'(1) << IB;

	`HRI_ASSERT_IMPL(a_recip_exact, $fell(busy_q), (mb <= one_shl) && (mb1 > one_shl), "reciprocal not floor(2^IB/b)")
	`HRI_ASSERT_NEXT(a_cfg_starts, cfg_valid && cfg_ready, busy_q, "write did not start reciprocal")

endmodule
`default_nettype wire

/* rtl/hri_digit.sv */
// One digit unit: three stages that peel one base digit off the index and fold it
// into the mirrored numerator and the power of the base. Depends on hri_pkg and the macros.
`default_nettype none
`include "halton_radical_inverse_macros.svh"
module hri_digit import hri_pkg::*; #(
	parameter int IB = 31,
	parameter int PW = 39
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire base_t         b,
	input  wire logic [IB-1:0] recip,
	input  wire logic          v_in,
	input  wire logic [IB-1:0] n_in,
	input  wire logic [PW-1:0] r_in,
	input  wire logic [PW-1:0] p_in,
	output logic               v_out,
	output logic [IB-1:0]      n_out,
	output logic [PW-1:0]      r_out,
	output logic [PW-1:0]      p_out
);
	logic            v_s1, v_s2, v_s3;
	logic [2*IB-1:0] prod_s1;
	logic [IB-1:0]   n_s1, qe_s2, n_s3;
	logic [PW-1:0]   r_s1, p_s1, r_s2, p_s2, r_s3, p_s3;
	logic            nz_s2;
	logic [BASE_W:0] rem_s2;

	logic [IB-1:0]   qe;
	logic [IB+7:0]   qb;
	logic [IB+7:0]   diff;
	logic            ge;
	logic [BASE_W:0] dig;
	logic [PW+7:0]   rb;
	logic [PW+7:0]   pb;

	assign qe   = prod_s1[2*IB-1:IB];
	assign qb   = (IB+8)'(qe) * (IB+8)'(b);
	assign diff = (IB+8)'(n_s1) - qb;
	assign ge   = rem_s2 >= {1'b0, b};
	assign dig  = ge ? rem_s2 - {1'b0, b} : rem_s2;
	assign rb   = (PW+8)'(r_s2) * (PW+8)'(b);
	assign pb   = (PW+8)'(p_s2) * (PW+8)'(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*IB)'(n_in) * (2*IB)'(recip);
			n_s1    <= n_in;
			r_s1    <= r_in;
			p_s1    <= p_in;
			qe_s2   <= qe;
			rem_s2  <= diff[BASE_W:0];
			nz_s2   <= n_s1 != '0;
			r_s2    <= r_s1;
			p_s2    <= p_s1;
			if (nz_s2) begin
				n_s3 <= qe_s2 + IB'(ge);
				r_s3 <= rb[PW-1:0] + PW'(dig[BASE_W-1:0]);
				p_s3 <= pb[PW-1:0];
			end else begin
				n_s3 <= '0;
				r_s3 <= r_s2;
				p_s3 <= p_s2;
			end
		end
	end

	assign v_out = v_s3;
	assign n_out = n_s3;
	assign r_out = r_s3;
	assign p_out = p_s3;

	`HRI_ASSERT_IMPL(a_rem_range, v_s2 && nz_s2, rem_s2 < ({1'b0, b} << 1), "digit estimate off by more than one")

endmodule
`default_nettype wire

/* rtl/hri_divider.sv */
// Restoring divider pipeline: floor(r * 2^FB / p), one quotient bit per stage.
// Depends on hri_pkg and the macros.
`default_nettype none
`include "halton_radical_inverse_macros.svh"
module hri_divider import hri_pkg::*; #(
	parameter int FB = 32,
	parameter int PW = 39
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          v_in,
	input  wire logic [PW-1:0] r_in,
	input  wire logic [PW-1:0] p_in,
	output logic               v_out,
	output logic [FB-1:0]      q_out
);
	logic [PW-1:0] rem_last;
	logic [PW-1:0] p_last;

	for (genvar i = 0; i < FB; i++) begin : g_stage
		logic          v_i;
		logic [PW-1:0] rem_i;
		logic [PW-1:0] p_i;
		logic [FB-1:0] q_i;
		logic [PW:0]   rem2;
		logic          ge;
		logic          v_s;
		logic [PW-1:0] rem_s;
		logic [PW-1:0] p_s;
		logic [FB-1:0] q_s;

		if (i == 0) begin : g_first
			assign v_i   = v_in;
			assign rem_i = r_in;
			assign p_i   = p_in;
			assign q_i   = '0;
		end else begin : g_next
			assign v_i   = g_stage[i-1].v_s;
			assign rem_i = g_stage[i-1].rem_s;
			assign p_i   = g_stage[i-1].p_s;
			assign q_i   = g_stage[i-1].q_s;
		end

		assign rem2 = {rem_i, 1'b0};
		assign ge   = rem2 >= {1'b0, p_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else if (en) begin
				v_s <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s <= ge ? PW'(rem2 - {1'b0, p_i}) : rem2[PW-1:0];
				p_s   <= p_i;
				q_s   <= {q_i[FB-2:0], ge};
			end
		end
	end

	assign v_out    = g_stage[FB-1].v_s;
	assign q_out    = g_stage[FB-1].q_s;
	assign rem_last = g_stage[FB-1].rem_s;
	assign p_last   = g_stage[FB-1].p_s;

	`HRI_ASSERT_IMPL(a_rem_below, v_out, rem_last < p_last, "divider remainder not below divisor")

endmodule
`default_nettype wire

/* rtl/halton_radical_inverse.sv */
// Channel  Handshake        Payload
// in       in_valid/stall   term_index
// out      out_valid/stall  fraction
// cfg      cfg_valid/ready  base
//
// Pipeline: three stages per digit unit, one per quotient bit of the final divider.
// One item per cycle when not stalled.
// A base write runs the reciprocal unit; input stalls meanwhile.
// out_stall freezes the whole pipeline while out_valid is high. Reset sets base to 2.
// Top level; depends on hri_pkg, hri_recip, hri_digit, hri_divider and the macros.
`default_nettype none
`include "halton_radical_inverse_macros.svh"
module halton_radical_inverse import hri_pkg::*; #(
	parameter int INDEX_BITS    = 31,
	parameter int FRACTION_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [INDEX_BITS-1:0]    term_index,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [FRACTION_BITS-1:0]      fraction,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire base_t                    base
);
	localparam int IB = INDEX_BITS;
	localparam int PW = INDEX_BITS + BASE_W;

	logic          en;
	logic          busy;
	base_t         b_eff;
	logic [IB-1:0] recip;

	logic          v_c [IB+1];
	logic [IB-1:0] n_c [IB+1];
	logic [PW-1:0] r_c [IB+1];
	logic [PW-1:0] p_c [IB+1];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en || busy;

	hri_recip #(.IB(IB)) u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.base     (base),
		.b_eff    (b_eff),
		.recip    (recip),
		.busy     (busy)
	);

	assign v_c[0] = in_valid && !busy;
	assign n_c[0] = term_index;
	assign r_c[0] = '0;
	assign p_c[0] = PW'(1);

	for (genvar i = 0; i < IB; i++) begin : g_digit
		hri_digit #(.IB(IB), .PW(PW)) u_digit (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.b     (b_eff),
			.recip (recip),
			.v_in  (v_c[i]),
			.n_in  (n_c[i]),
			.r_in  (r_c[i]),
			.p_in  (p_c[i]),
			.v_out (v_c[i+1]),
			.n_out (n_c[i+1]),
			.r_out (r_c[i+1]),
			.p_out (p_c[i+1])
		);
	end

	hri_divider #(.FB(FRACTION_BITS), .PW(PW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.v_in  (v_c[IB]),
		.r_in  (r_c[IB]),
		.p_in  (p_c[IB]),
		.v_out (out_valid),
		.q_out (fraction)
	);

	`HRI_ASSERT_IMPL(a_digits_done, v_c[IB], n_c[IB] == '0, "index not fully consumed by digit units")
	`HRI_ASSERT_IMPL(a_num_below_pow, v_c[IB], r_c[IB] < p_c[IB], "mirrored numerator not below base power")

endmodule
`default_nettype wire

/* tb/halton_radical_inverse_tb.sv */
// Testbench for halton_radical_inverse: directed and random term indexes in several bases.
// Predicts each fraction by exact digit mirroring and long division; needs hri_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module halton_radical_inverse_tb;
	import hri_pkg::*;

	localparam int INDEX_BITS    = 31;
	localparam int FRACTION_BITS = 32;
	localparam int LATENCY       = 3 * INDEX_BITS + FRACTION_BITS;
	localparam longint CYCLE_LIMIT = 2000000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [INDEX_BITS-1:0]    term_index = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [FRACTION_BITS-1:0] fraction;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	base_t                    base = RESET_BASE;

	base_t                    radix = RESET_BASE;
	logic [FRACTION_BITS-1:0] fraction_queue[$];
	int                       errors = 0;
	longint                   cycles = 0;
	int                       send_idle_pct = 0;
	int                       stall_pct = 0;

	halton_radical_inverse #(
		.INDEX_BITS(INDEX_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.term_index(term_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fraction(fraction),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.base(base)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[halton_radical_inverse] ERROR");
			$finish;
		end
	end

	function automatic logic [FRACTION_BITS-1:0] radical_inverse(
			input logic [INDEX_BITS-1:0] idx, input base_t raw);
		logic [7:0]               digits[64];
		int                       count;
		logic [63:0]              n;
		logic [31:0]              b;
		logic [31:0]              rem;
		logic [FRACTION_BITS-1:0] acc;
		logic [FRACTION_BITS-1:0] quo;
		count = 0;
		n = 64'(idx);
		b = (raw < 8'd2) ? 32'd2 : 32'(raw);
		acc = '0;
		while (n != 0) begin
			digits[count] = 8'(n % b);
			n = n / b;
			count++;
		end
		while (count > 0) begin
			count--;
			rem = 32'(digits[count]);
			quo = '0;
			for (int i = FRACTION_BITS - 1; i >= 0; i--) begin
				rem = (rem << 1) | 32'(acc[i]);
				quo = quo << 1;
				if (rem >= b) begin
					rem = rem - b;
					quo[0] = 1'b1;
				end
			end
			acc = quo;
		end
		return acc;
	endfunction

	task automatic report(input string what, input logic [FRACTION_BITS-1:0] got,
			input logic [FRACTION_BITS-1:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (fraction_queue.size() == 0) begin
				report("unexpected beat", fraction, '0);
			end else begin
				logic [FRACTION_BITS-1:0] want;
				want = fraction_queue.pop_front();
				if (fraction !== want)
					report("fraction", fraction, want);
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_index(input logic [INDEX_BITS-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		term_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		fraction_queue = {fraction_queue, radical_inverse(idx, radix)};
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (fraction_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_base(input base_t value);
		drain();
		cfg_valid <= 1'b1;
		base <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		radix = value;
	endtask

	function automatic logic [INDEX_BITS-1:0] random_index();
		case ($urandom_range(3))
			0: return INDEX_BITS'($urandom_range(300));
			1: return INDEX_BITS'($urandom) >> $urandom_range(INDEX_BITS - 1);
			default: return INDEX_BITS'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [INDEX_BITS-1:0] edges[8];
		edges = '{'0, 1, 2, 3, {INDEX_BITS{1'b1}}, 31'h4000_0000, 31'h2AAA_AAAA, 31'h5555_5555};
		foreach (edges[i]) send_index(edges[i]);
		for (int i = 0; i < 8; i++) send_index(INDEX_BITS'(radix) ** i);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) send_index(random_index());
	endtask

	task automatic test_bases();
		base_t picks[7];
		picks = '{8'd0, 8'd1, 8'd3, 8'd255, 8'd7, 8'd128, 8'd2};
		foreach (picks[i]) begin
			write_base(picks[i]);
			test_directed();
			test_random(30);
		end
	endtask

	task automatic test_idling();
		int idle[4];
		int stl[4];
		idle = '{0, 60, 0, 30};
		stl  = '{0, 0, 60, 30};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle[p];
			stall_pct = stl[p];
			write_base(base_t'($urandom_range(255)));
			test_random(60);
			write_base(8'd5);
			test_random(50);
			drain();
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_bases();
		test_idling();
		drain();
		if (errors == 0)
			$display("[halton_radical_inverse] OK");
		else
			$display("[halton_radical_inverse] ERROR");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl
rtl/hri_pkg.sv
rtl/hri_recip.sv
rtl/hri_digit.sv
rtl/hri_divider.sv
rtl/halton_radical_inverse.sv
tb/halton_radical_inverse_tb.sv
